// File: rtl/core/mphc_pkg.sv
// Shared types and constants of the multichannel pump controller.
// No dependencies.
`default_nettype none

package mphc_pkg;

  localparam int CHANNELS = 4;
  localparam int CIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [6:0]  PCT_FULL = 7'd100;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;

  // request kinds
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_CMD    = 2'd2;

  // pump commands
  localparam logic [1:0] CMD_MAN_ON  = 2'd0;
  localparam logic [1:0] CMD_MAN_OFF = 2'd1;
  localparam logic [1:0] CMD_AUTO    = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_START_PCT  = 3'd0;
  localparam logic [2:0] CFG_STOP_PCT   = 3'd1;
  localparam logic [2:0] CFG_AUTO_EN    = 3'd2;
  localparam logic [2:0] CFG_MAX_RUN    = 3'd3;
  localparam logic [2:0] CFG_COOLDOWN   = 3'd4;
  localparam logic [2:0] CFG_DRY_RAW    = 3'd5;
  localparam logic [2:0] CFG_WET_RAW    = 3'd6;
  localparam logic [2:0] CFG_ACTIVE_LOW = 3'd7;

  typedef enum logic [1:0] {
    MODE_AUTO    = 2'd0,
    MODE_MAN_ON  = 2'd1,
    MODE_MAN_OFF = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_WSAMP,
    ST_CMD,
    ST_TINC,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic samp_wr;
    logic cmd_apply;
    logic tick_inc;
    logic check;
    logic out_load;
  } mphc_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       div_last;
    logic       check_last;
    logic       out_stall;
  } mphc_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/multichannel_pump_hysteresis_controller_unit.sv
// Top level of the multichannel pump controller: sequencer plus datapath.
// Depends on mphc_pkg, mphc_ctrl and mphc_dpath.
`default_nettype none

// Hysteresis on/off pump controller for CHANNELS channels (package constant,
// 4 by default) with a runtime limit and a restart cooldown. One beat in
// gives exactly one result beat out. A sample beat converts a raw reading
// into a percent through a bit-serial divider: one setup step with the x100
// multiply, 7 quotient iterations, one write and one result load. A tick
// beat bumps all run/off counters at once, then the check unit visits
// one channel per cycle before the result load. A command beat applies
// its command, then loads the result; an unknown request kind only
// reports. The input side takes a new beat as soon as the sequencer is
// back in idle, while an earlier result may still sit in the output
// register; a stalled output holds the sequencer in its last step.
// Configuration writes are registered and must only be issued while no
// beat is in flight. Result masks cover channels 0..3 only; relay levels
// are the pump bits XOR the relay invert register.
module multichannel_pump_hysteresis_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [1:0]  in_channel,
  input  wire logic [9:0]  in_raw_value,
  input  wire logic [1:0]  in_command,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_pump_mask,
  output logic [3:0]       out_relay_levels,
  output logic [3:0]       out_started_mask,
  output logic [3:0]       out_target_stop_mask,
  output logic [3:0]       out_limit_stop_mask,
  output logic [6:0]       out_soil_pct,
  output logic [1:0]       out_channel_mode
);
  import mphc_pkg::*;

  mphc_cmd_t cmd;   // sequencer -> datapath step strobes
  mphc_sts_t sts;   // datapath -> sequencer: beat kind, loop ends, stall

  mphc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mphc_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_req_type          (in_req_type),
    .in_channel           (in_channel),
    .in_raw_value         (in_raw_value),
    .in_command           (in_command),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pump_mask        (out_pump_mask),
    .out_relay_levels     (out_relay_levels),
    .out_started_mask     (out_started_mask),
    .out_target_stop_mask (out_target_stop_mask),
    .out_limit_stop_mask  (out_limit_stop_mask),
    .out_soil_pct         (out_soil_pct),
    .out_channel_mode     (out_channel_mode),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

`default_nettype wire

// File: rtl/core/mphc_ctrl.sv
// Sequencer of the pump controller: walks each beat through its steps.
// Depends on mphc_pkg.
`default_nettype none

module mphc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mphc_pkg::mphc_sts_t sts,
  output mphc_pkg::mphc_cmd_t     cmd
);
  import mphc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_FINISH;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_WSAMP;
        end
      end
      ST_WSAMP: begin
        cmd.samp_wr = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_CMD: begin
        cmd.cmd_apply = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_TINC: begin
        cmd.tick_inc = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.check_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // dispatch on the kind of the beat just captured
    if (state_r == ST_IDLE && in_valid) begin
      case (sts.req)
        REQ_SAMPLE: state_nxt = ST_PREP;
        REQ_TICK:   state_nxt = ST_TINC;
        REQ_CMD:    state_nxt = ST_CMD;
        default:    state_nxt = ST_FINISH;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mphc_dpath.sv
// Datapath of the pump controller: registers, channel state, percent divider,
// per-channel check unit and result register. Depends on mphc_pkg.
`default_nettype none

module mphc_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [1:0]          in_channel,
  input  wire logic [9:0]          in_raw_value,
  input  wire logic [1:0]          in_command,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               out_pump_mask,
  output logic [3:0]               out_relay_levels,
  output logic [3:0]               out_started_mask,
  output logic [3:0]               out_target_stop_mask,
  output logic [3:0]               out_limit_stop_mask,
  output logic [6:0]               out_soil_pct,
  output logic [1:0]               out_channel_mode,
  input  wire mphc_pkg::mphc_cmd_t cmd,
  output mphc_pkg::mphc_sts_t      sts
);
  import mphc_pkg::*;

  // configuration registers
  logic [6:0]  start_pct_r, stop_pct_r;
  logic        auto_en_r, active_low_r;
  logic [15:0] max_run_r, cooldown_r;
  logic [9:0]  dry_raw_r, wet_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pct_r  <= 7'd35;
      stop_pct_r   <= 7'd55;
      auto_en_r    <= 1'b0;
      max_run_r    <= 16'd15000;
      cooldown_r   <= 16'd30000;
      dry_raw_r    <= 10'd0;
      wet_raw_r    <= 10'd626;
      active_low_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_PCT:  start_pct_r  <= cfg_wdata[6:0];
        CFG_STOP_PCT:   stop_pct_r   <= cfg_wdata[6:0];
        CFG_AUTO_EN:    auto_en_r    <= cfg_wdata[0];
        CFG_MAX_RUN:    max_run_r    <= cfg_wdata;
        CFG_COOLDOWN:   cooldown_r   <= cfg_wdata;
        CFG_DRY_RAW:    dry_raw_r    <= cfg_wdata[9:0];
        CFG_WET_RAW:    wet_raw_r    <= cfg_wdata[9:0];
        CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic [1:0] item_ch_r, item_cmd_r;
  logic [9:0] item_raw_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_ch_r  <= in_channel;
      item_raw_r <= in_raw_value;
      item_cmd_r <= in_command;
    end
  end

  logic              ch_ok;
  logic [CIDX_W-1:0] item_idx;
  assign ch_ok    = 32'(item_ch_r) < CHANNELS;
  assign item_idx = CIDX_W'(item_ch_r);

  // percent divider: magnitudes of (raw-dry) and (wet-dry); quotient < 100
  // unless |num| >= |span|, which saturates at 100
  logic [10:0] diff_s, span_s;
  logic [9:0]  num_mag, span_mag;
  logic [16:0] rem_r;
  logic [9:0]  dvs_r;
  logic [6:0]  quo_r;
  logic [2:0]  div_k_r;
  logic        zero_r, sat_r;
  logic [16:0] trial;
  logic [6:0]  pct;

  assign diff_s   = {1'b0, item_raw_r} - {1'b0, dry_raw_r};
  assign span_s   = {1'b0, wet_raw_r} - {1'b0, dry_raw_r};
  assign num_mag  = diff_s[10] ? 10'(-diff_s) : diff_s[9:0];
  assign span_mag = span_s[10] ? 10'(-span_s) : span_s[9:0];
  assign trial    = 17'(dvs_r) << div_k_r;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      zero_r  <= (span_s == '0) || (diff_s == '0) || (diff_s[10] != span_s[10]);
      sat_r   <= num_mag >= span_mag;
      rem_r   <= 17'(num_mag) * 17'(PCT_FULL);
      dvs_r   <= span_mag;
      quo_r   <= '0;
      div_k_r <= 3'd6;
    end else if (cmd.div_step) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        quo_r <= {quo_r[5:0], 1'b1};
      end else begin
        quo_r <= {quo_r[5:0], 1'b0};
      end
      div_k_r <= div_k_r - 3'd1;
    end
  end

  assign pct = zero_r ? 7'd0 : (sat_r ? PCT_FULL : quo_r);

  // channel state
  logic        run_r   [CHANNELS];
  mode_t       mode_r  [CHANNELS];
  logic [6:0]  moist_r [CHANNELS];
  logic [15:0] run_el_r[CHANNELS];
  logic [15:0] off_el_r[CHANNELS];
  logic        run_nxt   [CHANNELS];
  mode_t       mode_nxt  [CHANNELS];
  logic [6:0]  moist_nxt [CHANNELS];
  logic [15:0] run_el_nxt[CHANNELS];
  logic [15:0] off_el_nxt[CHANNELS];

  logic [CIDX_W-1:0] chk_idx_r;
  logic [3:0]        started_r, tstop_r, lstop_r;
  logic [3:0]        started_nxt, tstop_nxt, lstop_nxt;
  logic [CIDX_W-1:0] rd_idx;
  logic              c_run;
  mode_t             c_mode;
  logic [6:0]        c_moist;
  logic [15:0]       c_run_el, c_off_el;

  // single read port: the check index while checking, else the item channel
  assign rd_idx   = cmd.check ? chk_idx_r : item_idx;
  assign c_run    = run_r[rd_idx];
  assign c_mode   = mode_r[rd_idx];
  assign c_moist  = moist_r[rd_idx];
  assign c_run_el = run_el_r[rd_idx];
  assign c_off_el = off_el_r[rd_idx];

  always_comb begin
    run_nxt     = run_r;
    mode_nxt    = mode_r;
    moist_nxt   = moist_r;
    run_el_nxt  = run_el_r;
    off_el_nxt  = off_el_r;
    started_nxt = started_r;
    tstop_nxt   = tstop_r;
    lstop_nxt   = lstop_r;
    if (cmd.capture) begin
      started_nxt = '0;
      tstop_nxt   = '0;
      lstop_nxt   = '0;
    end
    if (cmd.tick_inc) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (run_el_r[i] != CNT_MAX) run_el_nxt[i] = run_el_r[i] + 16'd1;
        if (off_el_r[i] != CNT_MAX) off_el_nxt[i] = off_el_r[i] + 16'd1;
      end
    end
    if (cmd.samp_wr && ch_ok) begin
      moist_nxt[item_idx] = pct;
    end
    if (cmd.cmd_apply && ch_ok) begin
      case (item_cmd_r)
        CMD_MAN_ON: begin
          mode_nxt[item_idx]   = MODE_MAN_ON;
          run_nxt[item_idx]    = 1'b1;
          run_el_nxt[item_idx] = '0;
        end
        CMD_MAN_OFF: begin
          mode_nxt[item_idx]   = MODE_MAN_OFF;
          run_nxt[item_idx]    = 1'b0;
          off_el_nxt[item_idx] = '0;
        end
        CMD_AUTO: mode_nxt[item_idx] = MODE_AUTO;
        default: ;
      endcase
    end
    if (cmd.check) begin
      if (c_run && c_run_el >= max_run_r) begin
        // runtime limit, any mode
        if (c_mode == MODE_MAN_ON) mode_nxt[chk_idx_r] = MODE_MAN_OFF;
        run_nxt[chk_idx_r]    = 1'b0;
        off_el_nxt[chk_idx_r] = '0;
        lstop_nxt             = lstop_r | (4'b0001 << chk_idx_r);
      end else if (auto_en_r && c_mode == MODE_AUTO) begin
        if (!c_run) begin
          if (c_off_el >= cooldown_r && c_moist <= start_pct_r) begin
            run_nxt[chk_idx_r]    = 1'b1;
            run_el_nxt[chk_idx_r] = '0;
            started_nxt           = started_r | (4'b0001 << chk_idx_r);
          end
        end else if (c_moist >= stop_pct_r) begin
          run_nxt[chk_idx_r]    = 1'b0;
          off_el_nxt[chk_idx_r] = '0;
          tstop_nxt             = tstop_r | (4'b0001 << chk_idx_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        run_r[i]    <= 1'b0;
        mode_r[i]   <= MODE_AUTO;
        moist_r[i]  <= '0;
        run_el_r[i] <= '0;
        off_el_r[i] <= CNT_MAX;
      end
      started_r <= '0;
      tstop_r   <= '0;
      lstop_r   <= '0;
    end else begin
      run_r     <= run_nxt;
      mode_r    <= mode_nxt;
      moist_r   <= moist_nxt;
      run_el_r  <= run_el_nxt;
      off_el_r  <= off_el_nxt;
      started_r <= started_nxt;
      tstop_r   <= tstop_nxt;
      lstop_r   <= lstop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_inc) begin
      chk_idx_r <= '0;
    end else if (cmd.check) begin
      chk_idx_r <= chk_idx_r + CIDX_W'(1);
    end
  end

  // result register
  logic [3:0] pm_w, rl_w;
  logic       out_valid_r;

  for (genvar b = 0; b < 4; b++) begin : g_bit
    if (b < CHANNELS) begin : g_on
      assign pm_w[b] = run_r[b];
      assign rl_w[b] = run_r[b] ^ active_low_r;
    end else begin : g_off
      assign pm_w[b] = 1'b0;
      assign rl_w[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pump_mask        <= pm_w;
      out_relay_levels     <= rl_w;
      out_started_mask     <= started_r;
      out_target_stop_mask <= tstop_r;
      out_limit_stop_mask  <= lstop_r;
      out_soil_pct         <= ch_ok ? c_moist : 7'd0;
      out_channel_mode     <= ch_ok ? c_mode : 2'd0;
    end
  end

  // beat kind is looked at only in idle, on the beat being offered
  assign out_valid      = out_valid_r;
  assign sts.req        = in_req_type;
  assign sts.div_last   = div_k_r == 3'd0;
  assign sts.check_last = chk_idx_r == CIDX_W'(CHANNELS - 1);
  assign sts.out_stall  = out_valid_r && !out_ready;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result not presented after load");

  a_started_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_started_mask & ~out_pump_mask) == 4'd0)
    else $error("auto-started channel reported idle");

  a_limit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_limit_stop_mask & out_pump_mask) == 4'd0)
    else $error("limit-stopped channel reported running");

  a_man_on_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r[0] == MODE_MAN_ON) |-> run_r[0])
    else $error("manual-on channel not running");

  a_man_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r[0] == MODE_MAN_OFF) |-> !run_r[0])
    else $error("manual-off channel running");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the multichannel pump hysteresis controller.
// Depends on mphc_pkg and multichannel_pump_hysteresis_controller_unit.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mphc_pkg::*;

  // request kind and command code that the block must ignore
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int ITEMS_PER_PHASE = 160;
  localparam int RAND_PHASES     = 8;
  localparam int SETTLE_CYCLES   = 16;     // sample beat is the slowest
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_AT         = 900;    // result count where the long output stall starts
  localparam int HOLD_CYCLES     = 80;
  localparam int QUIET_LO        = 500;    // no idling on either side in this beat window
  localparam int QUIET_HI        = 700;

  typedef struct packed {
    logic [1:0] req;
    logic [1:0] chan;
    logic [9:0] raw;
    logic [1:0] cmd;
  } pump_beat_t;

  typedef struct packed {
    logic [3:0] pumps;
    logic [3:0] relays;
    logic [3:0] started;
    logic [3:0] target_stop;
    logic [3:0] limit_stop;
    logic [6:0] moisture;
    logic [1:0] mode;
  } pump_status_t;

  // ---------------------------------------------------------------------------
  // DUT pins; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [1:0]  in_channel = '0;
  logic [9:0]  in_raw_value = '0;
  logic [1:0]  in_command = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_pump_mask;
  logic [3:0]  out_relay_levels;
  logic [3:0]  out_started_mask;
  logic [3:0]  out_target_stop_mask;
  logic [3:0]  out_limit_stop_mask;
  logic [6:0]  out_soil_pct;
  logic [1:0]  out_channel_mode;

  multichannel_pump_hysteresis_controller_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_channel           (in_channel),
    .in_raw_value         (in_raw_value),
    .in_command           (in_command),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pump_mask        (out_pump_mask),
    .out_relay_levels     (out_relay_levels),
    .out_started_mask     (out_started_mask),
    .out_target_stop_mask (out_target_stop_mask),
    .out_limit_stop_mask  (out_limit_stop_mask),
    .out_soil_pct         (out_soil_pct),
    .out_channel_mode     (out_channel_mode)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller: register mirror plus per-channel state
  // ---------------------------------------------------------------------------
  logic [6:0]  start_pct, stop_pct;
  logic        auto_on, relay_inv;
  logic [15:0] run_limit, cooldown;
  logic [9:0]  dry_level, wet_level;

  logic        pump_on  [CHANNELS];
  mode_t       ch_mode  [CHANNELS];
  logic [6:0]  moist_pct[CHANNELS];
  logic [15:0] run_ms   [CHANNELS];
  logic [15:0] off_ms   [CHANNELS];

  pump_beat_t   pending_beats[$];     // stimulus not yet on the bus
  pump_status_t expected_status[$];   // predicted results, oldest first
  pump_beat_t   sent_beat;            // beat currently offered on the input
  int           beats_in = 0;
  int           results_seen = 0;
  int           errors = 0;
  int           cycle_count = 0;

  // Starting a pump restarts its run timer, stopping it restarts the off timer.
  function automatic void drive_pump(int ch, logic on);
    pump_on[ch] = on;
    if (on) run_ms[ch] = '0;
    else    off_ms[ch] = '0;
  endfunction

  // Applies one accepted beat to the shadow state and returns the status
  // beat the block must produce for it.
  function automatic pump_status_t next_pump_status(pump_beat_t b);
    pump_status_t r;
    int  span, pct;
    bit  addr_ok;
    r = '0;
    addr_ok = int'(b.chan) < CHANNELS;
    case (b.req)
      REQ_SAMPLE: if (addr_ok) begin
        span = int'(wet_level) - int'(dry_level);
        if (span == 0) pct = 0;     // degenerate calibration reads as bone dry
        else begin
          // signed divide truncates toward zero, then clamp to 0..100
          pct = (int'(b.raw) - int'(dry_level)) * 100 / span;
          if (pct < 0) pct = 0;
          if (pct > 100) pct = 100;
        end
        moist_pct[b.chan] = pct[6:0];
      end
      REQ_CMD: if (addr_ok) begin
        case (b.cmd)
          CMD_MAN_ON: begin
            ch_mode[b.chan] = MODE_MAN_ON;
            drive_pump(b.chan, 1'b1);
          end
          CMD_MAN_OFF: begin
            ch_mode[b.chan] = MODE_MAN_OFF;
            drive_pump(b.chan, 1'b0);
          end
          CMD_AUTO: ch_mode[b.chan] = MODE_AUTO;
          default: ;
        endcase
      end
      REQ_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (run_ms[i] != CNT_MAX) run_ms[i]++;
          if (off_ms[i] != CNT_MAX) off_ms[i]++;
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (pump_on[i] && run_ms[i] >= run_limit) begin
            // runtime limit wins in every mode; manual on falls back to off
            if (ch_mode[i] == MODE_MAN_ON) ch_mode[i] = MODE_MAN_OFF;
            drive_pump(i, 1'b0);
            if (i < 4) r.limit_stop[i] = 1'b1;
          end else if (auto_on && ch_mode[i] == MODE_AUTO) begin
            if (!pump_on[i]) begin
              if (off_ms[i] >= cooldown && moist_pct[i] <= start_pct) begin
                drive_pump(i, 1'b1);
                if (i < 4) r.started[i] = 1'b1;
              end
            end else if (moist_pct[i] >= stop_pct) begin
              drive_pump(i, 1'b0);
              if (i < 4) r.target_stop[i] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < CHANNELS && i < 4; i++) begin
      r.pumps[i]  = pump_on[i];
      r.relays[i] = pump_on[i] ^ relay_inv;
    end
    if (addr_ok) begin
      r.moisture = moist_pct[b.chan];
      r.mode     = ch_mode[b.chan];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: pops the pending queue, predicts at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_status.push_back(next_pump_status(sent_beat));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || in_ready) begin
        // random gaps, except for one long stretch of back-to-back beats
        if (pending_beats.size() != 0 &&
            ((beats_in >= QUIET_LO && beats_in < QUIET_HI) ||
             $urandom_range(0, 99) >= 12)) begin
          sent_beat = pending_beats.pop_front();
          in_req_type  <= sent_beat.req;
          in_channel   <= sent_beat.chan;
          in_raw_value <= sent_beat.raw;
          in_command   <= sent_beat.cmd;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output ready: random stalls, one quiet window and one long hold-off.
  // During the hold the sender keeps offering beats, so the block backs up
  // and drops in_ready.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_seen >= QUIET_LO && results_seen < QUIET_HI) ||
                   ($urandom_range(0, 99) >= 12);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  pump_status_t want_status;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_status.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual pump_mask %0d",
                 $time, out_pump_mask);
        errors++;
      end else begin
        want_status = expected_status.pop_front();
        check_field("pump_mask", 16'(want_status.pumps), 16'(out_pump_mask));
        check_field("relay_levels", 16'(want_status.relays), 16'(out_relay_levels));
        check_field("started_mask", 16'(want_status.started), 16'(out_started_mask));
        check_field("target_stop_mask", 16'(want_status.target_stop),
                    16'(out_target_stop_mask));
        check_field("limit_stop_mask", 16'(want_status.limit_stop),
                    16'(out_limit_stop_mask));
        check_field("soil_pct", 16'(want_status.moisture), 16'(out_soil_pct));
        check_field("channel_mode", 16'(want_status.mode), 16'(out_channel_mode));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_status.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // one register write, mirrored in the shadow copy; only called while idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_START_PCT:  start_pct = val[6:0];
      CFG_STOP_PCT:   stop_pct  = val[6:0];
      CFG_AUTO_EN:    auto_on   = val[0];
      CFG_MAX_RUN:    run_limit = val;
      CFG_COOLDOWN:   cooldown  = val;
      CFG_DRY_RAW:    dry_level = val[9:0];
      CFG_WET_RAW:    wet_level = val[9:0];
      CFG_ACTIVE_LOW: relay_inv = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_controls(logic [15:0] start_v, logic [15:0] stop_v, logic [15:0] auto_v,
                              logic [15:0] run_v, logic [15:0] cool_v, logic [15:0] dry_v,
                              logic [15:0] wet_v, logic [15:0] inv_v);
    write_reg(CFG_START_PCT,  start_v);
    write_reg(CFG_STOP_PCT,   stop_v);
    write_reg(CFG_AUTO_EN,    auto_v);
    write_reg(CFG_MAX_RUN,    run_v);
    write_reg(CFG_COOLDOWN,   cool_v);
    write_reg(CFG_DRY_RAW,    dry_v);
    write_reg(CFG_WET_RAW,    wet_v);
    write_reg(CFG_ACTIVE_LOW, inv_v);
  endtask

  task automatic queue_beat(logic [1:0] req, logic [1:0] chan, logic [9:0] raw,
                            logic [1:0] cmd);
    pump_beat_t b;
    b.req  = req;
    b.chan = chan;
    b.raw  = raw;
    b.cmd  = cmd;
    pending_beats.push_back(b);
  endtask

  // sender stops until every predicted result is back, then lets the
  // sequencer settle before any register write
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly ticks so the timers move, a steady flow of samples and commands,
  // and a little noise (unknown request kinds and commands).
  function automatic pump_beat_t random_beat();
    pump_beat_t b;
    int k;
    k      = $urandom_range(0, 99);
    b.chan = 2'($urandom_range(0, 3));
    b.raw  = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 3))
      0:       b.cmd = CMD_MAN_ON;
      1:       b.cmd = CMD_MAN_OFF;
      default: b.cmd = CMD_AUTO;   // bias toward auto so hysteresis gets exercised
    endcase
    if (k < 55)      b.req = REQ_TICK;
    else if (k < 80) b.req = REQ_SAMPLE;
    else if (k < 95) b.req = REQ_CMD;
    else if (k < 98) b.req = REQ_NONE;
    else begin
      b.req = REQ_CMD;
      b.cmd = CMD_NONE;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // power-on register values and channel state
    start_pct = 7'd35;
    stop_pct  = 7'd55;
    auto_on   = 1'b0;
    run_limit = 16'd15000;
    cooldown  = 16'd30000;
    dry_level = 10'd0;
    wet_level = 10'd626;
    relay_inv = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      pump_on[i]   = 1'b0;
      ch_mode[i]   = MODE_AUTO;
      moist_pct[i] = '0;
      run_ms[i]    = '0;
      off_ms[i]    = CNT_MAX;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: conversion extremes under the reset calibration
    queue_beat(REQ_SAMPLE, 2'd0, 10'd0,    CMD_AUTO);   // 0 percent
    queue_beat(REQ_SAMPLE, 2'd1, 10'd1023, CMD_AUTO);   // clamps at 100
    queue_beat(REQ_SAMPLE, 2'd2, 10'd313,  CMD_AUTO);   // mid scale
    queue_beat(REQ_SAMPLE, 2'd3, 10'd626,  CMD_AUTO);   // exactly wet
    // every command, repeated manual on, manual off on an idle pump, bad code
    queue_beat(REQ_CMD, 2'd0, 10'd0, CMD_MAN_ON);
    queue_beat(REQ_CMD, 2'd0, 10'd0, CMD_MAN_ON);
    queue_beat(REQ_CMD, 2'd1, 10'd0, CMD_MAN_OFF);
    queue_beat(REQ_CMD, 2'd2, 10'd0, CMD_AUTO);
    queue_beat(REQ_CMD, 2'd3, 10'd0, CMD_NONE);
    queue_beat(REQ_NONE, 2'd1, 10'd1023, CMD_NONE);     // unknown kind only reports
    queue_beat(REQ_TICK, 2'd0, 10'd0, CMD_AUTO);
    wait_idle();

    // equal calibration points always read zero
    write_reg(CFG_DRY_RAW, 16'd500);
    write_reg(CFG_WET_RAW, 16'd500);
    queue_beat(REQ_SAMPLE, 2'd0, 10'd500,  CMD_AUTO);
    queue_beat(REQ_SAMPLE, 2'd1, 10'd1023, CMD_AUTO);
    wait_idle();

    // reversed calibration: negative span
    write_reg(CFG_DRY_RAW, 16'd1023);
    write_reg(CFG_WET_RAW, 16'd0);
    queue_beat(REQ_SAMPLE, 2'd2, 10'd0,    CMD_AUTO);
    queue_beat(REQ_SAMPLE, 2'd3, 10'd1023, CMD_AUTO);
    wait_idle();

    // auto watering with a very short runtime limit and no cooldown
    set_controls(16'd100, 16'd100, 16'd1, 16'd2, 16'd0, 16'd0, 16'd1023, 16'd0);
    for (int i = 0; i < 6; i++) queue_beat(REQ_TICK, i[1:0], 10'd0, CMD_AUTO);
    queue_beat(REQ_CMD, 2'd0, 10'd0, CMD_AUTO);
    queue_beat(REQ_TICK, 2'd0, 10'd0, CMD_AUTO);
    queue_beat(REQ_TICK, 2'd3, 10'd0, CMD_AUTO);
    wait_idle();

    // random phases; the first two pin the register extremes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_controls(16'd0, 16'd100, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd0);
        1: set_controls(16'd100, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd0, 16'd1);
        default:
          set_controls(16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                       16'($urandom_range(0, 4) != 0), 16'($urandom_range(1, 40)),
                       16'($urandom_range(0, 50)), 16'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1)));
      endcase
      repeat (ITEMS_PER_PHASE) pending_beats.push_back(random_beat());
      wait_idle();
    end

    if (expected_status.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, expected_status.size());
      errors++;
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
